@@ sv/brb_pkg.sv @@
// Shared definitions for the byte ring buffer with staged writes.
// Operation codes and the control word from the pointer logic to the byte store.
// No dependencies.
package brb_pkg;

	// operation codes carried in the op field
	localparam logic [2:0] OP_WRITE   = 3'd0;
	localparam logic [2:0] OP_READ    = 3'd1;
	localparam logic [2:0] OP_SKIP    = 3'd2;
	localparam logic [2:0] OP_PREPARE = 3'd3;
	localparam logic [2:0] OP_COMMIT  = 3'd4;

	// strobes for the byte store, valid in the cycle a word is accepted
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} brb_mem_ctl_t;

endpackage

@@ sv/brb_mem.sv @@
// Byte store of the ring buffer: one write port, one read port with registered data.
// Depends on brb_pkg for the control word.
module brb_mem #(
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  logic                clk,
	input  brb_pkg::brb_mem_ctl_t ctl,
	input  logic [AW-1:0]       wr_addr,
	input  logic [7:0]          wr_data,
	input  logic [AW-1:0]       rd_addr,
	output logic [7:0]          rd_data_s1
);
	import brb_pkg::*;

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule

@@ sv/brb_ctrl.sv @@
// Pointer logic of the ring buffer: decodes each word, updates head and tail,
// drives the byte store and holds the result register. Depends on brb_pkg.
module brb_ctrl #(
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            op,
	input  logic [7:0]            data_in,
	input  logic [7:0]            count,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            readable,
	output logic [7:0]            writable,
	output logic                  error,
	output logic                  rd_hit,
	output brb_pkg::brb_mem_ctl_t mem_ctl,
	output logic [AW-1:0]         wr_addr,
	output logic [7:0]            wr_data,
	output logic [AW-1:0]         rd_addr
);
	import brb_pkg::*;

	// compare width: holds DEPTH, a byte count and one carry
	localparam int CW = ((AW > 8) ? AW : 8) + 2;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C = CW'(1);
	localparam logic [CW-1:0] TWO_C = CW'(2);

	logic [AW-1:0] head_q, tail_q;
	logic [AW-1:0] head_n, tail_n;
	logic          out_valid_q;
	logic [7:0]    readable_s1, writable_s1;
	logic          error_s1, rd_hit_s1;

	logic          accept;
	logic [CW-1:0] used, space, used_n, space_n, cnt;
	logic          err;
	logic          do_wr, do_rd;
	logic [AW-1:0] prep_addr;

	// (head - tail) mod DEPTH
	function automatic logic [CW-1:0] fill(input logic [AW-1:0] h, input logic [AW-1:0] t);
		logic [CW-1:0] he, te;
		he = CW'(h);
		te = CW'(t);
		return (he >= te) ? (he - te) : (he + DEPTH_C - te);
	endfunction

	// (pos + n) mod DEPTH for n below DEPTH
	function automatic logic [AW-1:0] adv(input logic [AW-1:0] pos, input logic [CW-1:0] n);
		logic [CW-1:0] s;
		s = CW'(pos) + n;
		if (s >= DEPTH_C) begin
			s = s - DEPTH_C;
		end
		return s[AW-1:0];
	endfunction

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign used      = fill(head_q, tail_q);
	assign space     = DEPTH_C - ONE_C - used;
	assign cnt       = CW'(count);
	assign prep_addr = adv(head_q, cnt);

	// operation decode and bounds checks
	always_comb begin
		head_n = head_q;
		tail_n = tail_q;
		err    = 1'b0;
		do_wr  = 1'b0;
		do_rd  = 1'b0;
		unique case (op)
			OP_WRITE: begin
				if (space == '0) begin
					err = 1'b1;
				end else begin
					do_wr  = 1'b1;
					head_n = adv(head_q, ONE_C);
				end
			end
			OP_READ: begin
				if (used == '0) begin
					err = 1'b1;
				end else begin
					do_rd  = 1'b1;
					tail_n = adv(tail_q, ONE_C);
				end
			end
			OP_SKIP: begin
				if (cnt == '0 || cnt > used) begin
					err = 1'b1;
				end else begin
					tail_n = adv(tail_q, cnt);
				end
			end
			OP_PREPARE: begin
				if (cnt + TWO_C >= DEPTH_C) begin
					err = 1'b1;
				end else begin
					do_wr = 1'b1;
				end
			end
			OP_COMMIT: begin
				if (cnt > space) begin
					err = 1'b1;
				end else begin
					head_n = adv(head_q, cnt);
				end
			end
			default: begin
				err = 1'b1;
			end
		endcase
	end

	assign used_n  = fill(head_n, tail_n);
	assign space_n = DEPTH_C - ONE_C - used_n;

	// byte store strobes; prepare writes ahead of head
	assign mem_ctl.wr_en = accept && do_wr;
	assign mem_ctl.rd_en = accept && do_rd;
	assign wr_addr       = (op == OP_PREPARE) ? prep_addr : head_q;
	assign wr_data       = data_in;
	assign rd_addr       = tail_q;

	// pointers and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				head_q <= head_n;
				tail_q <= tail_n;
			end
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			readable_s1 <= used_n[7:0];
			writable_s1 <= space_n[7:0];
			error_s1    <= err;
			rd_hit_s1   <= do_rd;
		end
	end

	assign out_valid = out_valid_q;
	assign readable  = readable_s1;
	assign writable  = writable_s1;
	assign error     = error_s1;
	assign rd_hit    = rd_hit_s1;

endmodule

@@ sv/byte_ring_buffer_staged_write.sv @@
// Top level of the byte ring buffer with staged writes.
// Instantiates brb_ctrl and brb_mem; depends on brb_pkg.
//
// A ring of DEPTH bytes, DEPTH-1 usable, driven by one operation word per
// cycle: write, read, skip, prepare (store ahead of head) and commit (publish
// prepared bytes). Each accepted word gives one result word
// from the result register, with the popped byte, the bytes readable, the
// space writable and an error flag for refused operations. The block takes
// one word every cycle: the pointer update is a single compare and add, the
// byte store has one write port and one registered read port, and the input
// stays open while a result waits as long as that result is taken in the same
// cycle. The byte store is not cleared after reset; a commit does not check that
// its bytes were prepared, so an entry can read back before it is written.
module byte_ring_buffer_staged_write #(
	parameter int DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] op,
	input  logic [7:0] data_in,
	input  logic [7:0] count,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic [7:0] readable,
	output logic [7:0] writable,
	output logic       error
);
	import brb_pkg::*;

	localparam int AW = $clog2(DEPTH);

	brb_mem_ctl_t  mem_ctl;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0]    wr_data, rd_data_s1;
	logic          rd_hit;

	brb_ctrl #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.data_in(data_in),
		.count(count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.readable(readable),
		.writable(writable),
		.error(error),
		.rd_hit(rd_hit),
		.mem_ctl(mem_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr)
	);

	brb_mem #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.ctl(mem_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data_s1(rd_data_s1)
	);

	// popped byte only for a read that went through
	assign read_data = rd_hit ? rd_data_s1 : 8'd0;

endmodule
